// ----- src/json_string_unescape_utf8_assert.svh -----
// Assertion macros shared by the JSON string unescaper modules.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH
`define JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define JSU_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jsu assertion failed");

// Next-cycle implication, checked outside reset.
`define JSU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jsu assertion failed");

`endif

// ----- src/jsu_pkg.sv -----
// Types, constants and decode functions for the JSON string unescaper.
// Used by jsu_front, jsu_queue, jsu_back and json_string_unescape_utf8.
`default_nettype none

package jsu_pkg;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_DONE = 2'd1,
        KIND_ERR  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_NO_OPEN   = 3'd1,
        ERR_DANGLING  = 3'd2,
        ERR_BAD_U     = 3'd3,
        ERR_NO_LOW    = 3'd4,
        ERR_BAD_LOW   = 3'd5,
        ERR_UNKNOWN   = 3'd6,
        ERR_UNTERM    = 3'd7
    } err_t;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_TEXT = 3'd1,
        PH_ESC  = 3'd2,
        PH_HIGH = 3'd3,
        PH_BSL  = 3'd4,
        PH_LU   = 3'd5,
        PH_LOW  = 3'd6
    } phase_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       final_req;
    } req_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] out_byte;
        err_t       error_code;
        logic       last;
    } res_t;

    // Work for one accepted byte: up to four data bytes, then an optional
    // done or error item.
    typedef struct packed {
        logic [3:0][7:0] data;
        logic [2:0]      n_data;
        logic            term_valid;
        kind_t           term_kind;
        err_t            term_code;
    } desc_t;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      len;
    } utf8_t;

    localparam logic [7:0]  CH_QUOTE     = 8'h22;
    localparam logic [7:0]  CH_BSLASH    = 8'h5C;
    localparam logic [7:0]  CH_U         = 8'h75;
    localparam logic [15:0] HIGH_MIN     = 16'hD800;
    localparam logic [15:0] HIGH_MAX     = 16'hDBFF;
    localparam logic [15:0] LOW_MIN      = 16'hDC00;
    localparam logic [15:0] LOW_MAX      = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE    = 21'h10000;
    localparam logic [20:0] LIM_ONE      = 21'h80;
    localparam logic [20:0] LIM_TWO      = 21'h800;
    localparam logic [7:0]  LEAD_TWO     = 8'hC0;
    localparam logic [7:0]  LEAD_THREE   = 8'hE0;
    localparam logic [7:0]  LEAD_FOUR    = 8'hF0;
    localparam logic [7:0]  CONT_MARK    = 8'h80;

    // Returns {valid, value} for one hex digit of either case.
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    // Returns {valid, byte} for a single-character escape letter.
    function automatic logic [8:0] esc_decode(input logic [7:0] c);
        logic [8:0] r;
        unique case (c)
            8'h22:   r = {1'b1, 8'h22};
            8'h5C:   r = {1'b1, 8'h5C};
            8'h2F:   r = {1'b1, 8'h2F};
            8'h62:   r = {1'b1, 8'h08};
            8'h66:   r = {1'b1, 8'h0C};
            8'h6E:   r = {1'b1, 8'h0A};
            8'h72:   r = {1'b1, 8'h0D};
            8'h74:   r = {1'b1, 8'h09};
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic utf8_t utf8_encode(input logic [20:0] cp);
        utf8_t r;
        r = '0;
        priority if (cp < LIM_ONE) begin
            r.len      = 3'd1;
            r.bytes[0] = cp[7:0];
        end else if (cp < LIM_TWO) begin
            r.len      = 3'd2;
            r.bytes[0] = LEAD_TWO | {3'b000, cp[10:6]};
            r.bytes[1] = CONT_MARK | {2'b00, cp[5:0]};
        end else if (cp < SUPP_BASE) begin
            r.len      = 3'd3;
            r.bytes[0] = LEAD_THREE | {4'b0000, cp[15:12]};
            r.bytes[1] = CONT_MARK | {2'b00, cp[11:6]};
            r.bytes[2] = CONT_MARK | {2'b00, cp[5:0]};
        end else begin
            r.len      = 3'd4;
            r.bytes[0] = LEAD_FOUR | {5'b00000, cp[20:18]};
            r.bytes[1] = CONT_MARK | {2'b00, cp[17:12]};
            r.bytes[2] = CONT_MARK | {2'b00, cp[11:6]};
            r.bytes[3] = CONT_MARK | {2'b00, cp[5:0]};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- src/jsu_front.sv -----
// Front end of the unescaper: takes one byte per cycle while its queue has room,
// runs the string phase machine and pushes a work descriptor. Depends on jsu_pkg.
`default_nettype none

module jsu_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           byte_valid,
    output logic                byte_stall,
    input  wire jsu_pkg::req_t  byte_item,
    input  wire logic           q_full,
    output logic                q_push,
    output jsu_pkg::desc_t      q_desc
);
    import jsu_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [15:0] high_reg, high_next;
    logic [15:0] low_reg, low_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        bad_reg, bad_next;

    logic        accept;
    logic [7:0]  c;
    logic        fin;
    logic [4:0]  hex;
    logic [8:0]  esc;
    logic [15:0] high_shift;
    logic [15:0] low_shift;
    logic        group_done;
    logic        high_is_surr;
    logic        low_in_range;
    logic        bad_any;
    logic [20:0] pair_cp;
    utf8_t       enc_high;
    utf8_t       enc_pair;
    desc_t       d;

    assign byte_stall   = q_full;
    assign accept       = byte_valid && !q_full;
    assign c            = byte_item.in_byte;
    assign fin          = byte_item.final_req;
    assign hex          = hex_decode(c);
    assign esc          = esc_decode(c);
    assign high_shift   = {high_reg[11:0], hex[3:0]};
    assign low_shift    = {low_reg[11:0], hex[4] ? hex[3:0] : 4'd0};
    assign group_done   = (cnt_reg == 2'd3);
    assign high_is_surr = (high_shift >= HIGH_MIN) && (high_shift <= HIGH_MAX);
    assign low_in_range = (low_shift >= LOW_MIN) && (low_shift <= LOW_MAX);
    assign bad_any      = bad_reg || !hex[4];
    // Both halves are known to be in range here, so only their low ten bits count.
    assign pair_cp      = {1'b0, high_reg[9:0], low_shift[9:0]} + SUPP_BASE;
    assign enc_high     = utf8_encode({5'd0, high_shift});
    assign enc_pair     = utf8_encode(pair_cp);

    // Next phase and digit accumulators.
    always_comb begin
        phase_next = phase_reg;
        high_next  = high_reg;
        low_next   = low_reg;
        cnt_next   = cnt_reg;
        bad_next   = bad_reg;
        unique case (phase_reg)
            PH_TEXT: begin
                if (c == CH_QUOTE) begin
                    phase_next = PH_IDLE;
                end else if (c == CH_BSLASH) begin
                    phase_next = fin ? PH_IDLE : PH_ESC;
                end else begin
                    phase_next = fin ? PH_IDLE : PH_TEXT;
                end
            end
            PH_ESC: begin
                if (esc[8]) begin
                    phase_next = fin ? PH_IDLE : PH_TEXT;
                end else if (c == CH_U && !fin) begin
                    phase_next = PH_HIGH;
                    high_next  = 16'd0;
                    cnt_next   = 2'd0;
                end else begin
                    phase_next = PH_IDLE;
                end
            end
            PH_HIGH: begin
                if (!hex[4]) begin
                    phase_next = PH_IDLE;
                end else begin
                    high_next = high_shift;
                    if (!group_done) begin
                        cnt_next = cnt_reg + 2'd1;
                        if (fin) begin
                            phase_next = PH_IDLE;
                        end
                    end else begin
                        cnt_next = 2'd0;
                        if (fin) begin
                            phase_next = PH_IDLE;
                        end else begin
                            phase_next = high_is_surr ? PH_BSL : PH_TEXT;
                        end
                    end
                end
            end
            PH_BSL: begin
                phase_next = (c != CH_BSLASH || fin) ? PH_IDLE : PH_LU;
            end
            PH_LU: begin
                if (c != CH_U || fin) begin
                    phase_next = PH_IDLE;
                end else begin
                    phase_next = PH_LOW;
                    low_next   = 16'd0;
                    cnt_next   = 2'd0;
                    bad_next   = 1'b0;
                end
            end
            PH_LOW: begin
                low_next = low_shift;
                if (!group_done) begin
                    cnt_next = cnt_reg + 2'd1;
                    bad_next = bad_any;
                    if (fin) begin
                        phase_next = PH_IDLE;
                    end
                end else begin
                    cnt_next = 2'd0;
                    bad_next = 1'b0;
                    if (bad_any || !low_in_range || fin) begin
                        phase_next = PH_IDLE;
                    end else begin
                        phase_next = PH_TEXT;
                    end
                end
            end
            default: begin
                phase_next = (c == CH_QUOTE && !fin) ? PH_TEXT : PH_IDLE;
            end
        endcase
    end

    // Descriptor for the results of the current byte.
    always_comb begin
        d = '0;
        d.term_kind = KIND_ERR;
        d.term_code = ERR_NONE;
        unique case (phase_reg)
            PH_TEXT: begin
                if (c == CH_QUOTE) begin
                    d.term_valid = 1'b1;
                    d.term_kind  = KIND_DONE;
                end else if (c == CH_BSLASH) begin
                    d.term_valid = fin;
                    d.term_code  = fin ? ERR_DANGLING : ERR_NONE;
                end else begin
                    d.data[0]    = c;
                    d.n_data     = 3'd1;
                    d.term_valid = fin;
                    d.term_code  = fin ? ERR_UNTERM : ERR_NONE;
                end
            end
            PH_ESC: begin
                if (esc[8]) begin
                    d.data[0]    = esc[7:0];
                    d.n_data     = 3'd1;
                    d.term_valid = fin;
                    d.term_code  = fin ? ERR_UNTERM : ERR_NONE;
                end else if (c == CH_U) begin
                    d.term_valid = fin;
                    d.term_code  = fin ? ERR_BAD_U : ERR_NONE;
                end else begin
                    d.term_valid = 1'b1;
                    d.term_code  = ERR_UNKNOWN;
                end
            end
            PH_HIGH: begin
                if (!hex[4]) begin
                    d.term_valid = 1'b1;
                    d.term_code  = ERR_BAD_U;
                end else if (!group_done) begin
                    d.term_valid = fin;
                    d.term_code  = fin ? ERR_BAD_U : ERR_NONE;
                end else if (high_is_surr) begin
                    d.term_valid = fin;
                    d.term_code  = fin ? ERR_NO_LOW : ERR_NONE;
                end else begin
                    d.data       = enc_high.bytes;
                    d.n_data     = enc_high.len;
                    d.term_valid = fin;
                    d.term_code  = fin ? ERR_UNTERM : ERR_NONE;
                end
            end
            PH_BSL: begin
                d.term_valid = (c != CH_BSLASH) || fin;
                d.term_code  = d.term_valid ? ERR_NO_LOW : ERR_NONE;
            end
            PH_LU: begin
                d.term_valid = (c != CH_U) || fin;
                d.term_code  = d.term_valid ? ERR_NO_LOW : ERR_NONE;
            end
            PH_LOW: begin
                if (!group_done) begin
                    // A truncated low group reports the missing surrogate even
                    // when one of its digits was bad.
                    d.term_valid = fin;
                    d.term_code  = fin ? ERR_NO_LOW : ERR_NONE;
                end else if (bad_any) begin
                    d.term_valid = 1'b1;
                    d.term_code  = ERR_BAD_U;
                end else if (!low_in_range) begin
                    d.term_valid = 1'b1;
                    d.term_code  = ERR_BAD_LOW;
                end else begin
                    d.data       = enc_pair.bytes;
                    d.n_data     = enc_pair.len;
                    d.term_valid = fin;
                    d.term_code  = fin ? ERR_UNTERM : ERR_NONE;
                end
            end
            default: begin
                if (c != CH_QUOTE) begin
                    d.term_valid = 1'b1;
                    d.term_code  = ERR_NO_OPEN;
                end else begin
                    d.term_valid = fin;
                    d.term_code  = fin ? ERR_UNTERM : ERR_NONE;
                end
            end
        endcase
    end

    assign q_desc = d;
    assign q_push = accept && (d.n_data != 3'd0 || d.term_valid);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            phase_reg <= PH_IDLE;
            high_reg  <= 16'd0;
            low_reg   <= 16'd0;
            cnt_reg   <= 2'd0;
            bad_reg   <= 1'b0;
        end else if (accept) begin
            phase_reg <= phase_next;
            high_reg  <= high_next;
            low_reg   <= low_next;
            cnt_reg   <= cnt_next;
            bad_reg   <= bad_next;
        end
    end

`include "json_string_unescape_utf8_assert.svh"

    `JSU_ASSERT_NOW(a_front_term_code, q_push && q_desc.term_valid, q_desc.term_kind != KIND_DATA && ((q_desc.term_kind == KIND_DONE) == (q_desc.term_code == ERR_NONE)))
    `JSU_ASSERT_NOW(a_front_fin_idle, accept && fin, phase_next == PH_IDLE)

endmodule

`default_nettype wire

// ----- src/jsu_queue.sv -----
// Small descriptor queue between the front and back ends of the unescaper.
// Depends on jsu_pkg for the descriptor type.
`default_nettype none

module jsu_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire jsu_pkg::desc_t  push_desc,
    output logic                 full,
    input  wire logic            pop,
    output logic                 head_valid,
    output jsu_pkg::desc_t       head_desc
);
    import jsu_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    desc_t          mem_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  cnt_reg, cnt_next;

    assign full       = (cnt_reg == CW'(DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_desc  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

`include "json_string_unescape_utf8_assert.svh"

    `JSU_ASSERT_NOW(a_queue_no_overflow, push, !full)
    `JSU_ASSERT_NOW(a_queue_no_underflow, pop, head_valid)

endmodule

`default_nettype wire

// ----- src/jsu_back.sv -----
// Back end of the unescaper: walks the head descriptor into its output register
// one result per cycle while not stalled, and marks the final one. Depends on jsu_pkg.
`default_nettype none

module jsu_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            head_valid,
    input  wire jsu_pkg::desc_t  head_desc,
    output logic                 pop,
    output logic                 res_valid,
    input  wire logic            res_stall,
    output jsu_pkg::res_t        res_item
);
    import jsu_pkg::*;

    logic [2:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    res_t       res_reg, res_next;

    logic [2:0] total;
    logic       load;
    res_t       cur;

    assign total = head_desc.n_data + {2'b00, head_desc.term_valid};
    assign load  = head_valid && (!valid_reg || !res_stall);

    always_comb begin
        cur = '0;
        cur.kind       = KIND_DATA;
        cur.error_code = ERR_NONE;
        if (idx_reg < head_desc.n_data) begin
            cur.out_byte = head_desc.data[idx_reg[1:0]];
        end else begin
            cur.kind       = head_desc.term_kind;
            cur.error_code = head_desc.term_code;
        end
        cur.last = (idx_reg == total - 3'd1);
    end

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg && res_stall;
        res_next   = res_reg;
        if (load) begin
            valid_next = 1'b1;
            res_next   = cur;
            idx_next   = cur.last ? 3'd0 : idx_reg + 3'd1;
        end
    end

    assign pop       = load && cur.last;
    assign res_valid = valid_reg;
    assign res_item  = res_reg;

    always_ff @(posedge clk) begin
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            idx_reg   <= 3'd0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

`include "json_string_unescape_utf8_assert.svh"

    `JSU_ASSERT_NOW(a_back_idx_range, head_valid, idx_reg < total)
    `JSU_ASSERT_NEXT(a_back_pop_last, pop, res_reg.last)

endmodule

`default_nettype wire

// ----- src/json_string_unescape_utf8.sv -----
// JSON string unescaper to UTF-8: takes the literal one byte per cycle,
// starting at its opening quote, and gives data bytes, a done item or an
// error item. The front end accepts a byte in every cycle in which its
// descriptor queue has room; the back end sends one result per cycle from
// its output register when not stalled, so a byte that yields k results (at most
// five, for a surrogate pair with a final-byte error) holds the back end until
// all k are sent. Plain text and one-letter escapes thus run at one byte per
// cycle unless stalled, and the QUEUE_DEPTH-entry queue absorbs the bursts of
// multi-byte code points. Bytes that yield no result (a backslash, hex digits)
// cost the back end nothing. Depends on jsu_pkg and the three submodules.
`default_nettype none

module json_string_unescape_utf8 #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           byte_valid,
    output logic                byte_stall,
    input  wire jsu_pkg::req_t  byte_item,
    output logic                res_valid,
    input  wire logic           res_stall,
    output jsu_pkg::res_t       res_item
);
    import jsu_pkg::*;

    logic  q_push;
    logic  q_full;
    logic  q_pop;
    logic  q_valid;
    desc_t q_in;
    desc_t q_head;

    jsu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_desc     (q_in)
    );

    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_desc  (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_desc  (q_head)
    );

    jsu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_valid),
        .head_desc  (q_head),
        .pop        (q_pop),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_item   (res_item)
    );

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// Testbench for json_string_unescape_utf8: a directed table, then random JSON string
// literals with broken and truncated ones mixed in, each result checked in order.
// Depends on jsu_pkg and the RTL of the unescaper.
module testbench;
    import jsu_pkg::*;

    localparam int RANDOM_BYTES = 390;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 40;

    // How a request's results are checked: by the predictor, as none, or as one typed result.
    typedef enum logic [1:0] {
        CHK_PRED,
        CHK_NONE,
        CHK_ONE
    } chk_t;

    typedef struct packed {
        logic [7:0] b;
        logic       fin;
        chk_t       chk;
        kind_t      k;
        logic [7:0] ob;
        err_t       code;
    } row_t;

    typedef struct packed {
        req_t req;
        chk_t chk;
        res_t typed;
    } plan_item_t;

    localparam row_t DIRECTED [25] = '{
        '{8'h78,     1'b0, CHK_ONE,  KIND_ERR,  8'h00, ERR_NO_OPEN},
        '{CH_QUOTE,  1'b1, CHK_ONE,  KIND_ERR,  8'h00, ERR_UNTERM},
        '{CH_QUOTE,  1'b0, CHK_NONE, KIND_DATA, 8'h00, ERR_NONE},
        '{8'h00,     1'b0, CHK_ONE,  KIND_DATA, 8'h00, ERR_NONE},
        '{8'hFF,     1'b0, CHK_ONE,  KIND_DATA, 8'hFF, ERR_NONE},
        '{CH_BSLASH, 1'b0, CHK_NONE, KIND_DATA, 8'h00, ERR_NONE},
        '{"t",       1'b0, CHK_ONE,  KIND_DATA, 8'h09, ERR_NONE},
        '{CH_BSLASH, 1'b0, CHK_NONE, KIND_DATA, 8'h00, ERR_NONE},
        '{CH_U,      1'b0, CHK_NONE, KIND_DATA, 8'h00, ERR_NONE},
        '{"D",       1'b0, CHK_NONE, KIND_DATA, 8'h00, ERR_NONE},
        '{"8",       1'b0, CHK_NONE, KIND_DATA, 8'h00, ERR_NONE},
        '{"3",       1'b0, CHK_NONE, KIND_DATA, 8'h00, ERR_NONE},
        '{"d",       1'b0, CHK_NONE, KIND_DATA, 8'h00, ERR_NONE},
        '{CH_BSLASH, 1'b0, CHK_NONE, KIND_DATA, 8'h00, ERR_NONE},
        '{CH_U,      1'b0, CHK_NONE, KIND_DATA, 8'h00, ERR_NONE},
        '{"d",       1'b0, CHK_NONE, KIND_DATA, 8'h00, ERR_NONE},
        '{"E",       1'b0, CHK_NONE, KIND_DATA, 8'h00, ERR_NONE},
        '{"0",       1'b0, CHK_NONE, KIND_DATA, 8'h00, ERR_NONE},
        '{"0",       1'b0, CHK_PRED, KIND_DATA, 8'h00, ERR_NONE},
        '{CH_BSLASH, 1'b0, CHK_NONE, KIND_DATA, 8'h00, ERR_NONE},
        '{"x",       1'b0, CHK_ONE,  KIND_ERR,  8'h00, ERR_UNKNOWN},
        '{CH_QUOTE,  1'b0, CHK_NONE, KIND_DATA, 8'h00, ERR_NONE},
        '{CH_BSLASH, 1'b1, CHK_ONE,  KIND_ERR,  8'h00, ERR_DANGLING},
        '{CH_QUOTE,  1'b0, CHK_NONE, KIND_DATA, 8'h00, ERR_NONE},
        '{CH_QUOTE,  1'b0, CHK_ONE,  KIND_DONE, 8'h00, ERR_NONE}
    };

    localparam logic [7:0] ESC_LETTERS [8] = '{CH_QUOTE, CH_BSLASH, "/", "b", "f", "n", "r", "t"};
    localparam logic [15:0] BMP_EDGES [8] = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF,
                                              16'h0800, 16'hD7FF, 16'hE000, 16'hFFFF};

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic byte_valid = 1'b0;
    logic byte_stall;
    req_t byte_item = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    res_t res_item;

    // Predictor state.
    phase_t      u_phase = PH_IDLE;
    logic [15:0] u_high = '0;
    logic [15:0] u_low = '0;
    logic [1:0]  u_digits = '0;
    logic        u_bad_digit = 1'b0;

    res_t       step_out[$];
    res_t       unescaped_q[$];
    plan_item_t byte_plan[$];
    plan_item_t on_wire;
    int         failures = 0;
    int         cycles = 0;
    int         send_gap = 0;
    int         stall_left = 0;

    json_string_unescape_utf8 DUT (
        .clk(clk),
        .rst_n(rst_n),
        .byte_valid(byte_valid),
        .byte_stall(byte_stall),
        .byte_item(byte_item),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res_item(res_item)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic void emit(input kind_t k, input logic [7:0] b, input err_t e);
        res_t r;
        r = '0;
        r.kind = k;
        r.out_byte = b;
        r.error_code = e;
        step_out = {step_out, r};
    endfunction

    function automatic void emit_data(input logic [7:0] b);
        emit(KIND_DATA, b, ERR_NONE);
    endfunction

    function automatic void abort(input err_t e);
        u_phase = PH_IDLE;
        emit(KIND_ERR, 8'h00, e);
    endfunction

    // Data went out and the string is still open, so a final byte here is unterminated.
    function automatic void stay_in_text(input logic fin);
        u_phase = PH_TEXT;
        if (fin)
            abort(ERR_UNTERM);
    endfunction

    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd0;
        if (c >= "0" && c <= "9")
            v = {1'b1, c[3:0]};
        else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F"))
            v = {1'b1, c[3:0] + 4'd9};
        return v;
    endfunction

    function automatic void emit_utf8(input logic [20:0] cp);
        if (cp < 21'h80)
        begin
            emit_data(cp[7:0]);
        end
        else if (cp < 21'h800)
        begin
            emit_data({3'b110, cp[10:6]});
            emit_data({2'b10, cp[5:0]});
        end
        else if (cp < 21'h10000)
        begin
            emit_data({4'b1110, cp[15:12]});
            emit_data({2'b10, cp[11:6]});
            emit_data({2'b10, cp[5:0]});
        end
        else
        begin
            emit_data({5'b11110, cp[20:18]});
            emit_data({2'b10, cp[17:12]});
            emit_data({2'b10, cp[11:6]});
            emit_data({2'b10, cp[5:0]});
        end
    endfunction

    // Advances the predictor by one request and leaves its results in step_out.
    function automatic void unescape_step(input req_t r);
        logic [7:0]  c;
        logic        fin;
        logic [4:0]  h;
        logic [7:0]  esc;
        logic        esc_ok;
        logic [15:0] hi_off;
        logic [15:0] lo_off;
        c = r.in_byte;
        fin = r.final_req;
        step_out.delete();
        case (u_phase)
            PH_TEXT:
            begin
                if (c == CH_QUOTE)
                begin
                    u_phase = PH_IDLE;
                    emit(KIND_DONE, 8'h00, ERR_NONE);
                end
                else if (c == CH_BSLASH)
                begin
                    if (fin)
                        abort(ERR_DANGLING);
                    else
                        u_phase = PH_ESC;
                end
                else
                begin
                    emit_data(c);
                    stay_in_text(fin);
                end
            end
            PH_ESC:
            begin
                esc_ok = 1'b1;
                esc = c;
                case (c)
                    "b": esc = 8'h08;
                    "f": esc = 8'h0C;
                    "n": esc = 8'h0A;
                    "r": esc = 8'h0D;
                    "t": esc = 8'h09;
                    CH_QUOTE, CH_BSLASH, "/": ;
                    default: esc_ok = 1'b0;
                endcase
                if (esc_ok)
                begin
                    emit_data(esc);
                    stay_in_text(fin);
                end
                else if (c == CH_U)
                begin
                    if (fin)
                    begin
                        abort(ERR_BAD_U);
                    end
                    else
                    begin
                        u_phase = PH_HIGH;
                        u_high = '0;
                        u_digits = '0;
                    end
                end
                else
                begin
                    abort(ERR_UNKNOWN);
                end
            end
            PH_HIGH:
            begin
                h = hex_digit(c);
                if (!h[4])
                begin
                    abort(ERR_BAD_U);
                end
                else
                begin
                    u_high = {u_high[11:0], h[3:0]};
                    if (u_digits < 2'd3)
                    begin
                        u_digits++;
                        if (fin)
                            abort(ERR_BAD_U);
                    end
                    else
                    begin
                        u_digits = '0;
                        if (u_high >= HIGH_MIN && u_high <= HIGH_MAX)
                        begin
                            if (fin)
                                abort(ERR_NO_LOW);
                            else
                                u_phase = PH_BSL;
                        end
                        else
                        begin
                            emit_utf8({5'd0, u_high});
                            stay_in_text(fin);
                        end
                    end
                end
            end
            PH_BSL:
            begin
                if (c != CH_BSLASH || fin)
                    abort(ERR_NO_LOW);
                else
                    u_phase = PH_LU;
            end
            PH_LU:
            begin
                if (c != CH_U || fin)
                begin
                    abort(ERR_NO_LOW);
                end
                else
                begin
                    u_phase = PH_LOW;
                    u_low = '0;
                    u_digits = '0;
                    u_bad_digit = 1'b0;
                end
            end
            PH_LOW:
            begin
                // A bad digit in the low group only shows once all four are in.
                h = hex_digit(c);
                if (!h[4])
                begin
                    u_bad_digit = 1'b1;
                    h = 5'd0;
                end
                u_low = {u_low[11:0], h[3:0]};
                if (u_digits < 2'd3)
                begin
                    u_digits++;
                    if (fin)
                        abort(ERR_NO_LOW);
                end
                else
                begin
                    u_digits = '0;
                    if (u_bad_digit)
                    begin
                        abort(ERR_BAD_U);
                    end
                    else if (u_low < LOW_MIN || u_low > LOW_MAX)
                    begin
                        abort(ERR_BAD_LOW);
                    end
                    else
                    begin
                        hi_off = u_high - HIGH_MIN;
                        lo_off = u_low - LOW_MIN;
                        emit_utf8(21'h10000 + {1'b0, hi_off[9:0], lo_off[9:0]});
                        stay_in_text(fin);
                    end
                    u_bad_digit = 1'b0;
                end
            end
            default:
            begin
                if (c != CH_QUOTE)
                    abort(ERR_NO_OPEN);
                else if (fin)
                    abort(ERR_UNTERM);
                else
                    u_phase = PH_TEXT;
            end
        endcase
        if (step_out.size() > 0)
            step_out[step_out.size() - 1].last = 1'b1;
    endfunction

    function automatic void plan(input logic [7:0] b, input logic fin);
        plan_item_t p;
        p = '0;
        p.req.in_byte = b;
        p.req.final_req = fin;
        p.chk = CHK_PRED;
        byte_plan = {byte_plan, p};
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return {4'h3, n};
        return ($urandom_range(0, 1) ? 8'h40 : 8'h60) | {4'h0, n - 4'd9};
    endfunction

    function automatic logic [7:0] pick_non_hex();
        logic [7:0] b;
        logic [4:0] h;
        b = 8'($urandom);
        h = hex_digit(b);
        while (h[4])
        begin
            b = 8'($urandom);
            h = hex_digit(b);
        end
        return b;
    endfunction

    function automatic void plan_unit(input logic [15:0] v);
        plan(CH_BSLASH, 1'b0);
        plan(CH_U, 1'b0);
        for (int i = 3; i >= 0; i--)
            plan(hex_char(v[4*i +: 4]), 1'b0);
    endfunction

    function automatic logic [15:0] pick_bmp();
        case ($urandom_range(0, 6))
            0: return 16'($urandom_range(16'h0000, 16'h007F));
            1: return 16'($urandom_range(16'h0080, 16'h07FF));
            2: return 16'($urandom_range(16'h0800, 16'hD7FF));
            3: return 16'($urandom_range(16'hE000, 16'hFFFF));
            4: return 16'($urandom_range(16'hDC00, 16'hDFFF));
            default: return BMP_EDGES[$urandom_range(0, 7)];
        endcase
    endfunction

    function automatic logic [15:0] pick_high();
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, 1) ? HIGH_MIN : HIGH_MAX;
        return 16'($urandom_range(16'hD800, 16'hDBFF));
    endfunction

    function automatic logic [15:0] pick_low();
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, 1) ? LOW_MIN : LOW_MAX;
        return 16'($urandom_range(16'hDC00, 16'hDFFF));
    endfunction

    // A string that goes wrong unless a random escape byte is valid; errors leave the block idle.
    function automatic void plan_broken();
        logic [15:0] lo;
        logic [7:0]  b;
        int          at;
        case ($urandom_range(0, 5))
            0:
            begin
                plan(CH_BSLASH, 1'b0);
                plan(8'($urandom), 1'b0);
            end
            1:
            begin
                plan(CH_BSLASH, 1'b0);
                plan(CH_U, 1'b0);
                at = $urandom_range(0, 3);
                for (int i = 0; i < at; i++)
                    plan(hex_char(4'($urandom)), 1'b0);
                plan(pick_non_hex(), 1'b0);
            end
            2:
            begin
                plan_unit(pick_high());
                plan(CH_BSLASH, 1'b0);
                plan(CH_U, 1'b0);
                at = $urandom_range(0, 3);
                lo = pick_low();
                for (int i = 3; i >= 0; i--)
                    plan(i == at ? pick_non_hex() : hex_char(lo[4*i +: 4]), 1'b0);
            end
            3:
            begin
                lo = 16'($urandom);
                if (lo >= LOW_MIN && lo <= LOW_MAX)
                    lo = lo ^ 16'h2000;
                plan_unit(pick_high());
                plan_unit(lo);
            end
            4:
            begin
                plan_unit(pick_high());
                b = 8'($urandom);
                if (b == CH_BSLASH)
                    b = CH_QUOTE;
                plan(b, 1'b0);
            end
            default:
            begin
                plan_unit(pick_high());
                plan(CH_BSLASH, 1'b0);
                b = 8'($urandom);
                if (b == CH_U)
                    b = 8'h55;
                plan(b, 1'b0);
            end
        endcase
    endfunction

    function automatic void plan_string();
        int         first;
        int         ntok;
        int         pos;
        logic       broken;
        logic [7:0] b;
        first = byte_plan.size();
        broken = 1'b0;
        plan(CH_QUOTE, 1'b0);
        ntok = $urandom_range(0, 6);
        for (int t = 0; t < ntok && !broken; t++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    b = 8'($urandom);
                    if (b == CH_QUOTE || b == CH_BSLASH)
                        b = b ^ 8'h01;
                    plan(b, 1'b0);
                end
                3, 4:
                begin
                    plan(CH_BSLASH, 1'b0);
                    plan(ESC_LETTERS[$urandom_range(0, 7)], 1'b0);
                end
                5, 6, 7:
                begin
                    plan_unit(pick_bmp());
                end
                8:
                begin
                    plan_unit(pick_high());
                    plan_unit(pick_low());
                end
                default:
                begin
                    plan_broken();
                    broken = 1'b1;
                end
            endcase
        end
        if (!broken)
            plan(CH_QUOTE, $urandom_range(0, 3) == 0);
        // Cutting some buffers short puts the final byte in every phase.
        if ($urandom_range(0, 5) == 0)
        begin
            pos = $urandom_range(first, byte_plan.size() - 1);
            byte_plan[pos].req.final_req = 1'b1;
            while (byte_plan.size() > pos + 1)
                void'(byte_plan.pop_back());
        end
    endfunction

    function automatic void plan_noise();
        int n;
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
            plan(8'($urandom), $urandom_range(0, 3) == 0);
    endfunction

    // Idling is off near the end of the run and during every third window of cycles.
    function automatic logic idling_on();
        return byte_plan.size() > 60 && (cycles / 300) % 3 != 2;
    endfunction

    always @(posedge clk)
    begin
        res_t want;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
        else if (rst_n)
        begin
            cycles++;

            if (byte_valid && !byte_stall)
            begin
                unescape_step(byte_item);
                case (on_wire.chk)
                    CHK_PRED:
                        unescaped_q = {unescaped_q, step_out};
                    CHK_ONE:
                        unescaped_q = {unescaped_q, on_wire.typed};
                    default: ;
                endcase
            end

            if (res_valid && !res_stall)
            begin
                if (unescaped_q.size() == 0)
                begin
                    $error("result with nothing expected: kind %0d, byte %02h, code %0d",
                           res_item.kind, res_item.out_byte, res_item.error_code);
                    failures++;
                end
                else
                begin
                    want = unescaped_q.pop_front();
                    if (res_item.kind !== want.kind)
                    begin
                        $error("kind: expected %0d, got %0d", want.kind, res_item.kind);
                        failures++;
                    end
                    if (res_item.out_byte !== want.out_byte)
                    begin
                        $error("out_byte: expected %02h, got %02h",
                               want.out_byte, res_item.out_byte);
                        failures++;
                    end
                    if (res_item.error_code !== want.error_code)
                    begin
                        $error("error_code: expected %0d, got %0d",
                               want.error_code, res_item.error_code);
                        failures++;
                    end
                    if (res_item.last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, res_item.last);
                        failures++;
                    end
                end
            end

            // The next request goes out once the current one is taken or none is pending.
            if (!byte_valid || !byte_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    byte_valid <= 1'b0;
                end
                else if (byte_plan.size() > 0)
                begin
                    on_wire = byte_plan.pop_front();
                    byte_item <= on_wire.req;
                    byte_valid <= 1'b1;
                    if (idling_on() && $urandom_range(0, 7) == 0)
                        send_gap = $urandom_range(1, 19);
                end
                else
                begin
                    byte_valid <= 1'b0;
                end
            end

            if (stall_left > 0)
            begin
                stall_left--;
                res_stall <= 1'b1;
            end
            else if (idling_on() && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(1, 19) - 1;
                res_stall <= 1'b1;
            end
            else
            begin
                res_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        plan_item_t p;
        int         n0;
        foreach (DIRECTED[i])
        begin
            p = '0;
            p.req.in_byte = DIRECTED[i].b;
            p.req.final_req = DIRECTED[i].fin;
            p.chk = DIRECTED[i].chk;
            p.typed.kind = DIRECTED[i].k;
            p.typed.out_byte = DIRECTED[i].ob;
            p.typed.error_code = DIRECTED[i].code;
            p.typed.last = 1'b1;
            byte_plan = {byte_plan, p};
        end
        n0 = byte_plan.size();
        while (byte_plan.size() - n0 < RANDOM_BYTES)
        begin
            if ($urandom_range(0, 9) == 0)
                plan_noise();
            else
                plan_string();
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        while (byte_plan.size() > 0 || byte_valid || unescaped_q.size() > 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (failures == 0 && unescaped_q.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+src
src/jsu_pkg.sv
src/jsu_front.sv
src/jsu_queue.sv
src/jsu_back.sv
src/json_string_unescape_utf8.sv
bench/testbench.sv
